FILE: rtl/ecev_pkg.sv
`default_nettype none
package ecev_pkg;

    // curve codes; code 7 has no curve and passes start through
    typedef enum logic [2:0] {
        CRV_LINEAR      = 3'd0,
        CRV_IN_CUBIC    = 3'd1,
        CRV_OUT_CUBIC   = 3'd2,
        CRV_INOUT_CUBIC = 3'd3,
        CRV_IN_BACK     = 3'd4,
        CRV_OUT_BACK    = 3'd5,
        CRV_INOUT_BACK  = 3'd6
    } t_curve;

    // back overshoot 1.70158 and 1.70158 * 1.525 as ratios
    localparam longint BACK_S_NUM  = 64'd170158;
    localparam longint BACK_S_DEN  = 64'd100000;
    localparam longint BACK_S2_NUM = 64'd25949095;
    localparam longint BACK_S2_DEN = 64'd10000000;

    localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    // per-transaction sideband carried along the pipe
    typedef struct packed {
        logic [2:0]         curve;
        logic signed [31:0] start_value;
        logic signed [31:0] change;
        logic               clamped;
        logic               dzero;
    } t_side;

    // weight control handed from curve stages to output stages
    typedef struct packed {
        logic byp;
        logic half;
    } t_wctl;

endpackage
`default_nettype wire

FILE: rtl/ecev_div.sv
`default_nettype none
module ecev_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ecev_pkg::t_side      i_side,
    input  logic [15:0]          i_elapsed,
    input  logic [15:0]          i_duration,
    output logic                 o_valid,
    output ecev_pkg::t_side      o_side,
    output logic [FRAC_BITS:0]   o_phase
);
    import ecev_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 17;

    logic          late;
    logic [15:0]   e_clip;
    logic [NW-1:0] num0;
    t_side         n_side;

    always_comb begin
        late   = i_elapsed > i_duration;
        e_clip = late ? i_duration : i_elapsed;
        num0   = ({{(NW-16){1'b0}}, e_clip} << FRAC_BITS)
               + {{(NW-15){1'b0}}, i_duration[15:1]};
        n_side = i_side;
        n_side.dzero   = (i_duration == 16'd0);
        n_side.clamped = late || (i_duration == 16'd0);
    end

    logic          r_v   [0:QW];
    t_side         r_sd  [0:QW];
    logic [15:0]   r_d   [0:QW];
    logic [15:0]   r_rem [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [QW-1:0] r_q   [0:QW];

    // entry register: rounded numerator split into partial remainder and low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_sd[0]  <= n_side;
            r_d[0]   <= i_duration;
            r_rem[0] <= num0[NW-1:QW];
            r_low[0] <= num0[QW-1:0];
            r_q[0]   <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [16:0] trial;
        logic        ge;
        assign trial = {r_rem[k-1], r_low[k-1][QW-1]};
        assign ge    = trial >= {1'b0, r_d[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_sd[k]  <= r_sd[k-1];
                r_d[k]   <= r_d[k-1];
                r_rem[k] <= ge ? 16'(trial - {1'b0, r_d[k-1]}) : trial[15:0];
                r_low[k] <= r_low[k-1] << 1;
                r_q[k]   <= {r_q[k-1][QW-2:0], ge};
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_side  = r_sd[QW];
    assign o_phase = r_sd[QW].dzero ? {1'b1, {FRAC_BITS{1'b0}}} : r_q[QW];

endmodule
`default_nettype wire

FILE: rtl/ecev_crv.sv
`default_nettype none
module ecev_crv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ecev_pkg::t_side               i_side,
    input  logic [FRAC_BITS:0]            i_phase,
    output logic                          o_valid,
    output ecev_pkg::t_side               o_side,
    output ecev_pkg::t_wctl               o_wctl,
    output logic signed [FRAC_BITS+7:0]   o_w
);
    import ecev_pkg::*;

    localparam int XW = FRAC_BITS + 3;
    localparam int OW = FRAC_BITS + 5;
    localparam int PW = 2 * OW;
    localparam int WW = FRAC_BITS + 8;

    localparam longint BACK_K  = ((BACK_S_NUM << FRAC_BITS) + BACK_S_DEN / 2) / BACK_S_DEN;
    localparam longint BACK_K2 = ((BACK_S2_NUM << FRAC_BITS) + BACK_S2_DEN / 2) / BACK_S2_DEN;
    localparam longint ONE_L   = longint'(1) << FRAC_BITS;

    localparam logic signed [XW-1:0] ONE_X = XW'(ONE_L);
    localparam logic signed [XW-1:0] TWO_X = XW'(2 * ONE_L);
    localparam logic signed [OW-1:0] K1    = OW'(BACK_K);
    localparam logic signed [OW-1:0] K2    = OW'(BACK_K2);
    localparam logic signed [OW-1:0] KP1_1 = OW'(BACK_K + ONE_L);
    localparam logic signed [OW-1:0] KP1_2 = OW'(BACK_K2 + ONE_L);
    localparam logic signed [WW-1:0] ONE_W = WW'(ONE_L);
    localparam logic signed [WW-1:0] TWO_W = WW'(2 * ONE_L);

    typedef struct packed {
        logic       lin;
        logic       cub;
        logic       kneg;
        logic       k2;
        logic       half;
        logic       byp;
        logic [1:0] off;
    } t_ctl;

    // product rounded half away from zero
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] pr);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = pr[PW-1] ? PW'(-pr) : PW'(pr);
        q   = (mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return pr[PW-1] ? -$signed(q) : $signed(q);
    endfunction

    // stage 1: operand and curve decode
    logic signed [XW-1:0] pe, u, n1_x;
    logic                 lowhalf;
    t_ctl                 n1_ctl;

    always_comb begin
        pe      = $signed({2'b00, i_phase});
        u       = pe <<< 1;
        lowhalf = u < ONE_X;
        n1_x    = pe;
        n1_ctl  = '0;
        unique case (i_side.curve)
            CRV_LINEAR: begin
                n1_ctl.lin = 1'b1;
            end
            CRV_IN_CUBIC: begin
                n1_ctl.cub = 1'b1;
            end
            CRV_OUT_CUBIC: begin
                n1_ctl.cub = 1'b1;
                n1_x       = pe - ONE_X;
                n1_ctl.off = 2'd1;
            end
            CRV_INOUT_CUBIC: begin
                n1_ctl.cub  = 1'b1;
                n1_ctl.half = 1'b1;
                n1_x        = lowhalf ? u : u - TWO_X;
                n1_ctl.off  = lowhalf ? 2'd0 : 2'd2;
            end
            CRV_IN_BACK: begin
                n1_ctl.kneg = 1'b1;
            end
            CRV_OUT_BACK: begin
                n1_x       = pe - ONE_X;
                n1_ctl.off = 2'd1;
            end
            CRV_INOUT_BACK: begin
                n1_ctl.k2   = 1'b1;
                n1_ctl.half = 1'b1;
                n1_ctl.kneg = lowhalf;
                n1_x        = lowhalf ? u : u - TWO_X;
                n1_ctl.off  = lowhalf ? 2'd0 : 2'd2;
            end
            default: begin
                n1_ctl.byp = 1'b1;
            end
        endcase
        if (i_side.change == 32'sd0) begin
            n1_ctl.byp = 1'b1;
        end
    end

    logic                 r1_v;
    t_side                r1_sd;
    t_ctl                 r1_ctl;
    logic signed [XW-1:0] r1_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_sd  <= i_side;
            r1_ctl <= n1_ctl;
            r1_x   <= n1_x;
        end
    end

    // stage 2: square and the overshoot product
    logic signed [OW-1:0] xo, kop;
    logic signed [PW-1:0] pr_sq, pr_k;

    always_comb begin
        xo    = $signed({{(OW-XW){r1_x[XW-1]}}, r1_x});
        kop   = r1_ctl.k2 ? KP1_2 : KP1_1;
        pr_sq = PW'(xo) * PW'(xo);
        pr_k  = PW'(kop) * PW'(xo);
    end

    logic                 r2_v;
    t_side                r2_sd;
    t_ctl                 r2_ctl;
    logic signed [XW-1:0] r2_x;
    logic signed [OW-1:0] r2_sq, r2_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_sd  <= r1_sd;
            r2_ctl <= r1_ctl;
            r2_x   <= r1_x;
            r2_sq  <= OW'(rnd(pr_sq));
            r2_m   <= r1_ctl.cub ? xo : OW'(rnd(pr_k));
        end
    end

    // stage 3: final product and offset
    logic signed [OW-1:0] kk, t;
    logic signed [PW-1:0] pr_w;
    logic signed [WW-1:0] offv, n3_w;

    always_comb begin
        kk   = r2_ctl.k2 ? K2 : K1;
        t    = r2_ctl.cub ? r2_m : (r2_ctl.kneg ? r2_m - kk : r2_m + kk);
        pr_w = PW'(r2_sq) * PW'(t);
        offv = (r2_ctl.off == 2'd2) ? TWO_W : ((r2_ctl.off == 2'd1) ? ONE_W : '0);
        if (r2_ctl.lin) begin
            n3_w = $signed({{(WW-XW){r2_x[XW-1]}}, r2_x});
        end else begin
            n3_w = WW'(rnd(pr_w)) + offv;
        end
    end

    logic                 r3_v;
    t_side                r3_sd;
    t_wctl                r3_wc;
    logic signed [WW-1:0] r3_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_sd      <= r2_sd;
            r3_wc.byp  <= r2_ctl.byp;
            r3_wc.half <= r2_ctl.half;
            r3_w       <= n3_w;
        end
    end

    assign o_valid = r3_v;
    assign o_side  = r3_sd;
    assign o_wctl  = r3_wc;
    assign o_w     = r3_w;

endmodule
`default_nettype wire

FILE: rtl/ecev_out.sv
`default_nettype none
module ecev_out #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  ecev_pkg::t_side             i_side,
    input  ecev_pkg::t_wctl             i_wctl,
    input  logic signed [FRAC_BITS+7:0] i_w,
    output logic                        o_valid,
    output logic signed [31:0]          o_eased_value,
    output logic                        o_time_clamped,
    output logic                        o_saturated
);
    import ecev_pkg::*;

    localparam int WW = FRAC_BITS + 8;
    localparam int PW = 32 + WW;

    // stage a: change times weight
    logic signed [PW-1:0] n_prod;
    assign n_prod = PW'($signed(i_side.change)) * PW'(i_w);

    logic                 r_a_v;
    t_side                r_a_sd;
    t_wctl                r_a_wc;
    logic signed [PW-1:0] r_a_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            r_a_sd   <= i_side;
            r_a_wc   <= i_wctl;
            r_a_prod <= n_prod;
        end
    end

    // stage b: scale back with rounding half away from zero
    logic [PW-1:0]        mag, hv, q;
    logic signed [PW-1:0] n_r;

    always_comb begin
        mag = r_a_prod[PW-1] ? PW'(-r_a_prod) : PW'(r_a_prod);
        hv  = r_a_wc.half ? (PW'(1) << FRAC_BITS) : (PW'(1) << (FRAC_BITS - 1));
        q   = r_a_wc.half ? ((mag + hv) >> (FRAC_BITS + 1)) : ((mag + hv) >> FRAC_BITS);
        n_r = r_a_prod[PW-1] ? -$signed(q) : $signed(q);
    end

    logic                 r_b_v;
    t_side                r_b_sd;
    logic                 r_b_byp;
    logic signed [PW-1:0] r_b_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
        if (i_en) begin
            r_b_sd  <= r_a_sd;
            r_b_byp <= r_a_wc.byp;
            r_b_r   <= n_r;
        end
    end

    // stage c: add start and clip to 32 bits
    logic signed [PW:0]   sum;
    logic signed [31:0]   n_val;
    logic                 n_sat;

    always_comb begin
        sum   = (PW+1)'($signed(r_b_sd.start_value)) + (PW+1)'(r_b_r);
        n_val = r_b_sd.start_value;
        n_sat = 1'b0;
        if (!r_b_byp) begin
            if (sum > (PW+1)'(VAL_MAX)) begin
                n_val = VAL_MAX;
                n_sat = 1'b1;
            end else if (sum < (PW+1)'(VAL_MIN)) begin
                n_val = VAL_MIN;
                n_sat = 1'b1;
            end else begin
                n_val = sum[31:0];
            end
        end
    end

    logic               r_c_v;
    logic signed [31:0] r_c_val;
    logic               r_c_clamp;
    logic               r_c_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
        if (i_en) begin
            r_c_val   <= n_val;
            r_c_clamp <= r_b_sd.clamped;
            r_c_sat   <= n_sat;
        end
    end

    assign o_valid        = r_c_v;
    assign o_eased_value  = r_c_val;
    assign o_time_clamped = r_c_clamp;
    assign o_saturated    = r_c_sat;

endmodule
`default_nettype wire

FILE: rtl/easing_curve_evaluator_core.sv
`default_nettype none
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_curve, i_elapsed, i_start_value, i_change, i_duration
// output  | o_valid | i_stall | o_eased_value, o_time_clamped, o_saturated
//
// one transaction per cycle while the output is not stalled; latency is set mostly by the
// phase divider, which resolves one quotient bit per stage (FRAC_BITS + 1 stages)
// reset is synchronous, active low, and clears only the valid bits
// a stall at the output freezes the whole pipe, bubbles included; o_stall
// rises only while a result sits in the output register and i_stall is high
module easing_curve_evaluator_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_curve,
    input  logic [15:0]        i_elapsed,
    input  logic signed [31:0] i_start_value,
    input  logic signed [31:0] i_change,
    input  logic [15:0]        i_duration,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_eased_value,
    output logic               o_time_clamped,
    output logic               o_saturated
);
    import ecev_pkg::*;

    localparam int WW = FRAC_BITS + 8;

    // global advance: the pipe moves unless a finished result is held
    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // sideband entering the divider; clamp flags are set there
    t_side in_side;
    always_comb begin
        in_side.curve       = i_curve;
        in_side.start_value = i_start_value;
        in_side.change      = i_change;
        in_side.clamped     = 1'b0;
        in_side.dzero       = 1'b0;
    end

    // phase = round(min(elapsed, duration) * 2^FRAC_BITS / duration)
    logic               w_div_valid;
    t_side              w_div_side;
    logic [FRAC_BITS:0] w_div_phase;

    ecev_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (i_valid),
        .i_side     (in_side),
        .i_elapsed  (i_elapsed),
        .i_duration (i_duration),
        .o_valid    (w_div_valid),
        .o_side     (w_div_side),
        .o_phase    (w_div_phase)
    );

    // curve weight: square, overshoot term, final product
    logic                 w_crv_valid;
    t_side                w_crv_side;
    t_wctl                w_crv_wctl;
    logic signed [WW-1:0] w_crv_w;

    ecev_crv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_crv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (w_div_valid),
        .i_side  (w_div_side),
        .i_phase (w_div_phase),
        .o_valid (w_crv_valid),
        .o_side  (w_crv_side),
        .o_wctl  (w_crv_wctl),
        .o_w     (w_crv_w)
    );

    // scale change by weight, add start, saturate; last stage is the output register
    ecev_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_valid        (w_crv_valid),
        .i_side         (w_crv_side),
        .i_wctl         (w_crv_wctl),
        .i_w            (w_crv_w),
        .o_valid        (o_valid),
        .o_eased_value  (o_eased_value),
        .o_time_clamped (o_time_clamped),
        .o_saturated    (o_saturated)
    );

`ifndef ASSERT_OFF
    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_eased_value == VAL_MAX || o_eased_value == VAL_MIN))
        else $error("saturated result not at a bound");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("pipe stalled without a held result");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid |-> (w_div_phase <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("phase above one");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(w_div_phase) && $stable(w_crv_w)))
        else $error("pipe moved during a stall");
`endif

endmodule
`default_nettype wire

FILE: test/easing_curve_checker.sv
`default_nettype none
module easing_curve_checker
    import ecev_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_curve,
    input  logic [15:0]        i_elapsed,
    input  logic signed [31:0] i_start_value,
    input  logic signed [31:0] i_change,
    input  logic [15:0]        i_duration,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_eased_value,
    input  logic               i_time_clamped,
    input  logic               i_saturated,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int FB = 16;
    localparam longint ONE = longint'(1) << FB;
    localparam longint SB = ((BACK_S_NUM << FB) + BACK_S_DEN / 2) / BACK_S_DEN;
    localparam longint SB2 = ((BACK_S2_NUM << FB) + BACK_S2_DEN / 2) / BACK_S2_DEN;

    typedef struct {
        logic signed [31:0] value;
        logic               clamped;
        logic               sat;
    } t_eased;

    t_eased expected_q[$];
    int     errors = 0;

    assign o_errors  = errors;

    // product rounded half away from zero
    function automatic longint round_mul(longint a, longint b, int sh);
        longint ma, mb, m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m  = (ma * mb + (longint'(1) << (sh - 1))) >>> sh;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic t_eased ease(logic [2:0] crv, logic [15:0] el,
                                    logic signed [31:0] st, logic signed [31:0] ch,
                                    logic [15:0] dur);
        t_eased r;
        longint p, w, u, q, v, e;
        int sh;
        r.clamped = 0;
        r.sat = 0;
        sh = FB;
        w = 0;
        e = el;
        if (dur == 0) begin
            r.clamped = 1;
            p = ONE;
        end else begin
            if (el > dur) begin
                r.clamped = 1;
                e = dur;
            end
            p = ((e << FB) + dur / 2) / dur;
        end
        v = st;
        if (ch != 0 && crv != 3'd7) begin
            case (t_curve'(crv))
                CRV_LINEAR: w = p;
                CRV_IN_CUBIC: w = round_mul(round_mul(p, p, FB), p, FB);
                CRV_OUT_CUBIC: begin
                    q = p - ONE;
                    w = round_mul(round_mul(q, q, FB), q, FB) + ONE;
                end
                CRV_INOUT_CUBIC: begin
                    u = 2 * p;
                    sh = FB + 1;
                    if (u < ONE) w = round_mul(round_mul(u, u, FB), u, FB);
                    else begin
                        q = u - 2 * ONE;
                        w = round_mul(round_mul(q, q, FB), q, FB) + 2 * ONE;
                    end
                end
                CRV_IN_BACK:
                    w = round_mul(round_mul(p, p, FB), round_mul(SB + ONE, p, FB) - SB, FB);
                CRV_OUT_BACK: begin
                    q = p - ONE;
                    w = round_mul(round_mul(q, q, FB), round_mul(SB + ONE, q, FB) + SB, FB)
                        + ONE;
                end
                default: begin
                    u = 2 * p;
                    sh = FB + 1;
                    if (u < ONE) begin
                        w = round_mul(round_mul(u, u, FB),
                                      round_mul(SB2 + ONE, u, FB) - SB2, FB);
                    end else begin
                        q = u - 2 * ONE;
                        w = round_mul(round_mul(q, q, FB),
                                      round_mul(SB2 + ONE, q, FB) + SB2, FB) + 2 * ONE;
                    end
                end
            endcase
            v = longint'(st) + round_mul(longint'(ch), w, sh);
            if (v > longint'(VAL_MAX)) begin
                v = VAL_MAX;
                r.sat = 1;
            end else if (v < longint'(VAL_MIN)) begin
                v = VAL_MIN;
                r.sat = 1;
            end
        end
        r.value = v[31:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_eased exp_r;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall)
                expected_q.push_back(ease(i_curve, i_elapsed, i_start_value, i_change,
                                          i_duration));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) report("unexpected result", 1, 0);
                else begin
                    exp_r = expected_q.pop_front();
                    if (i_eased_value !== exp_r.value)
                        report("eased_value", i_eased_value, exp_r.value);
                    if (i_time_clamped !== exp_r.clamped)
                        report("time_clamped", i_time_clamped, exp_r.clamped);
                    if (i_saturated !== exp_r.sat)
                        report("saturated", i_saturated, exp_r.sat);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule
`default_nettype wire

FILE: test/easing_curve_evaluator_core_tb.sv
`default_nettype none
module easing_curve_evaluator_core_tb;
    import ecev_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [2:0]         curve = 0;
    logic [15:0]        elapsed = 0;
    logic signed [31:0] start_value = 0;
    logic signed [31:0] change = 0;
    logic [15:0]        duration = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] eased_value;
    logic               time_clamped;
    logic               saturated;
    int                 errors;
    int                 pending;
    bit                 hold_off = 0;
    int                 idle_cycles = 0;
    int                 n_sent = 0;

    always #5 clk = ~clk;

    easing_curve_evaluator_core u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_curve(curve), .i_elapsed(elapsed), .i_start_value(start_value),
        .i_change(change), .i_duration(duration), .o_valid(out_valid),
        .i_stall(out_stall), .o_eased_value(eased_value),
        .o_time_clamped(time_clamped), .o_saturated(saturated)
    );

    easing_curve_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_curve(curve), .i_elapsed(elapsed), .i_start_value(start_value),
        .i_change(change), .i_duration(duration), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_eased_value(eased_value),
        .i_time_clamped(time_clamped), .i_saturated(saturated),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: quiet stretches, busy stretches, and one long hold-off
    always @(negedge clk) begin
        int mode;
        mode = int'(($time / 20000) % 3);
        if (hold_off) out_stall <= 1;
        else if (mode == 0) out_stall <= 0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
    end

    // one long receiver hold-off once a good part of the stimulus is out
    initial begin
        wait (n_sent >= 500);
        @(negedge clk);
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
    end

    // watchdog: cycles with no accepted transaction on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // random 32-bit value, weighted toward small magnitudes and the extremes
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            3: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23)) << 4;
        endcase
    endfunction

    // offer one transaction and hold it until taken
    task automatic send(logic [2:0] c, logic [15:0] e, logic [31:0] s, logic [31:0] ch,
                        logic [15:0] d);
        curve <= c;
        elapsed <= e;
        start_value <= s;
        change <= ch;
        duration <= d;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic gap(int n);
        in_valid <= 0;
        repeat (n) @(negedge clk);
    endtask

    initial begin
        logic [15:0] d, e;
        int burst;
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: each curve at phase zero and one half, zero and late time, zero change
        for (int c = 0; c < 8; c++) begin
            send(3'(c), 16'd0, 32'h00010000, 32'h00640000, 16'd100);
            send(3'(c), 16'd50, 32'h7fffffff, 32'h7fffffff, 16'd100);
        end
        send(CRV_IN_BACK, 16'd30, 32'h80000000, 32'h7fffffff, 16'd100);
        send(CRV_OUT_BACK, 16'd200, 32'h0, 32'h80000000, 16'd100);
        send(CRV_LINEAR, 16'hffff, 32'h12345678, 32'h1000, 16'd0);
        send(CRV_INOUT_BACK, 16'hffff, 32'hffffffff, 32'h0, 16'hffff);
        send(CRV_INOUT_CUBIC, 16'h7fff, 32'h80000000, 32'h80000000, 16'hffff);
        send(CRV_OUT_CUBIC, 16'd1, 32'h0, 32'h7fffffff, 16'd1);
        gap(1);

        // random bursts; the long receiver hold-off runs in its own process
        for (int i = 0; i < 1530;) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++, i++) begin
                d = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1)) :
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
                e = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, d));
                send(3'($urandom_range(0, 7)), e, pick32(), pick32(), d);
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 12));
        end
        in_valid <= 0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/ecev_pkg.sv
rtl/ecev_div.sv
rtl/ecev_crv.sv
rtl/ecev_out.sv
rtl/easing_curve_evaluator_core.sv
test/easing_curve_checker.sv
test/easing_curve_evaluator_core_tb.sv
